// ===== rtl/srfp_pkg.sv =====
`default_nettype none

package srfp_pkg;

   localparam int FLAG_BITS = 12;

   localparam logic [31:0] FLAG_MASK = (FLAG_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << FLAG_BITS) - 64'd1);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic [3:0] FIELD_QNAME = 4'd0;
   localparam logic [3:0] FIELD_FLAG  = 4'd1;
   localparam logic [3:0] FIELD_POS   = 4'd3;
   localparam logic [3:0] FIELD_MAPQ  = 4'd4;
   localparam logic [3:0] FIELD_CIGAR = 4'd5;
   localparam logic [3:0] FIELD_PNEXT = 4'd7;
   localparam logic [3:0] FIELD_TLEN  = 4'd8;
   localparam logic [3:0] FIELD_OPT   = 4'd11;

   localparam logic [2:0] OPT_TAG_LAST    = 3'd1;
   localparam logic [2:0] OPT_VALUE_START = 3'd5;

   localparam logic [31:0] TLEN_NEG_LIMIT = 32'h8000_0000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_TEXT  = 3'd0,
      KIND_NUM   = 3'd1,
      KIND_CIGAR = 3'd2,
      KIND_TAG   = 3'd3,
      KIND_END   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       line_end;
      logic       is_tab;
      logic       is_digit;
      logic       is_minus;
      logic [3:0] digit;
   } cmd_type;

   function automatic logic is_numeric(input logic [3:0] f);
      return (f == FIELD_FLAG) || (f == FIELD_POS) || (f == FIELD_MAPQ) ||
             (f == FIELD_PNEXT) || (f == FIELD_TLEN);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srfp_front.sv =====
`default_nettype none

module srfp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       byte_in,
   input  wire logic             line_end,
   input  wire logic             push,
   output logic                  full,
   output logic                  cmd_valid,
   output srfp_pkg::cmd_type     cmd,
   input  wire logic             cmd_take
);
   import srfp_pkg::*;

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   cmd_type               cls;
   logic                  do_push, do_pop;

   always_comb begin
      cls.byte_val = byte_in;
      cls.line_end = line_end;
      cls.is_tab   = (byte_in == CH_TAB);
      cls.is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
      cls.is_minus = (byte_in == CH_MINUS);
      cls.digit    = 4'(byte_in - CH_ZERO);
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!do_push && do_pop) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/srfp_back.sv =====
`default_nettype none

module srfp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire srfp_pkg::cmd_type cmd,
   output logic                   cmd_take,
   output logic [2:0]             kind,
   output logic [3:0]             field_id,
   output logic [7:0]             char_out,
   output logic signed [32:0]     value,
   output logic [15:0]            tag,
   output logic                   last,
   output logic                   empty,
   input  wire logic              pop
);
   import srfp_pkg::*;

   logic [3:0]   field_ff, field_in;
   logic [31:0]  acc_ff, acc_in;
   logic         minus_ff, minus_in;
   logic [2:0]   opt_pos_ff, opt_pos_in;
   logic [7:0]   tag_first_ff, tag_first_in;

   logic         out_valid_ff, out_valid_in;
   kind_type     kind_ff, kind_in;
   logic [3:0]   fid_ff, fid_in;
   logic [7:0]   char_ff, char_in;
   logic [32:0]  value_ff, value_in;
   logic [15:0]  tag_ff, tag_in;
   logic         last_ff, last_in;

   logic         res;
   logic [35:0]  acc_sum;
   logic [31:0]  acc_dig;
   logic [31:0]  acc_num;
   logic         minus_num;
   logic [31:0]  tlen_mag;
   logic [32:0]  num_value;

   assign cmd_take = cmd_valid && (!out_valid_ff || pop);

   assign acc_sum = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + {32'd0, cmd.digit};
   assign acc_dig = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];

   always_comb begin
      if (cmd.is_tab) begin
         acc_num   = acc_ff;
         minus_num = minus_ff;
      end else begin
         acc_num   = cmd.is_digit ? acc_dig : acc_ff;
         minus_num = minus_ff || cmd.is_minus;
      end
      tlen_mag = (acc_num > TLEN_NEG_LIMIT) ? TLEN_NEG_LIMIT : acc_num;
      if (field_ff == FIELD_FLAG) begin
         num_value = {1'b0, acc_num & FLAG_MASK};
      end else if (field_ff == FIELD_TLEN && minus_num) begin
         num_value = 33'd0 - {1'b0, tlen_mag};
      end else begin
         num_value = {1'b0, acc_num};
      end
   end

   always_comb begin
      field_in     = field_ff;
      acc_in       = acc_ff;
      minus_in     = minus_ff;
      opt_pos_in   = opt_pos_ff;
      tag_first_in = tag_first_ff;
      res          = 1'b0;
      kind_in      = KIND_TEXT;
      fid_in       = field_ff;
      char_in      = '0;
      value_in     = '0;
      tag_in       = '0;
      last_in      = cmd.line_end;

      if (cmd.is_tab) begin
         if (is_numeric(field_ff)) begin
            res      = 1'b1;
            kind_in  = KIND_NUM;
            value_in = num_value;
         end
         if (field_ff < FIELD_OPT) begin
            field_in = 4'(field_ff + 1'b1);
         end
         acc_in     = '0;
         minus_in   = 1'b0;
         opt_pos_in = '0;
      end else if (is_numeric(field_ff)) begin
         acc_in   = acc_num;
         minus_in = minus_num;
         if (cmd.line_end) begin
            res      = 1'b1;
            kind_in  = KIND_NUM;
            value_in = num_value;
         end
      end else if (field_ff == FIELD_CIGAR) begin
         if (cmd.is_digit) begin
            acc_in = acc_dig;
         end else begin
            res      = 1'b1;
            kind_in  = KIND_CIGAR;
            char_in  = cmd.byte_val;
            value_in = {1'b0, acc_ff};
            acc_in   = '0;
         end
      end else if (field_ff >= FIELD_OPT) begin
         fid_in = FIELD_OPT;
         if (opt_pos_ff == '0) begin
            tag_first_in = cmd.byte_val;
         end else if (opt_pos_ff == OPT_TAG_LAST) begin
            res     = 1'b1;
            kind_in = KIND_TAG;
            tag_in  = {tag_first_ff, cmd.byte_val};
         end else if (opt_pos_ff >= OPT_VALUE_START) begin
            res     = 1'b1;
            kind_in = KIND_TEXT;
            char_in = cmd.byte_val;
         end
         if (opt_pos_ff < OPT_VALUE_START) begin
            opt_pos_in = 3'(opt_pos_ff + 1'b1);
         end
      end else begin
         res     = 1'b1;
         kind_in = KIND_TEXT;
         char_in = cmd.byte_val;
      end

      if (cmd.line_end) begin
         if (!res) begin
            res     = 1'b1;
            kind_in = KIND_END;
            fid_in  = field_ff;
         end
         field_in     = FIELD_QNAME;
         acc_in       = '0;
         minus_in     = 1'b0;
         opt_pos_in   = '0;
         tag_first_in = '0;
      end

      out_valid_in = out_valid_ff && !pop;
      if (cmd_take && res) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= FIELD_QNAME;
         acc_ff       <= '0;
         minus_ff     <= 1'b0;
         opt_pos_ff   <= '0;
         tag_first_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd_take) begin
            field_ff     <= field_in;
            acc_ff       <= acc_in;
            minus_ff     <= minus_in;
            opt_pos_ff   <= opt_pos_in;
            tag_first_ff <= tag_first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take && res) begin
         kind_ff  <= kind_in;
         fid_ff   <= fid_in;
         char_ff  <= char_in;
         value_ff <= value_in;
         tag_ff   <= tag_in;
         last_ff  <= last_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign kind     = kind_ff;
   assign field_id = fid_ff;
   assign char_out = char_ff;
   assign value    = value_ff;
   assign tag      = tag_ff;
   assign last     = last_ff;

endmodule

`default_nettype wire

// ===== rtl/sam_record_field_parser_top.sv =====
// channel   direction  handshake        payload
// req       in         push / full      byte_in[7:0], line_end
// rsp       out        empty / pop      kind, field_id, char_out, value[32:0], tag, last
//
// One byte per cycle sustained while rsp_pop keeps the result register free; a result
// passes through the four-entry byte queue and then the result register before it
// shows on the rsp ports, where it can be popped.
// Synchronous reset returns the parser to the first field and empties the byte queue and the result register.
// A held result stalls only the parser; bytes keep entering until the queue fills.
`default_nettype none

module sam_record_field_parser_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_byte_in,
   input  wire logic               req_line_end,
   input  wire logic               req_push,
   output logic                    req_full,
   output logic [2:0]              rsp_kind,
   output logic [3:0]              rsp_field_id,
   output logic [7:0]              rsp_char_out,
   output logic signed [32:0]      rsp_value,
   output logic [15:0]             rsp_tag,
   output logic                    rsp_last,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop
);
   import srfp_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_take;

   srfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_in   (req_byte_in),
      .line_end  (req_line_end),
      .push      (req_push),
      .full      (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   srfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .kind      (rsp_kind),
      .field_id  (rsp_field_id),
      .char_out  (rsp_char_out),
      .value     (rsp_value),
      .tag       (rsp_tag),
      .last      (rsp_last),
      .empty     (rsp_empty),
      .pop       (rsp_pop)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srfp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int TAIL_CYCLES = 10;

   typedef struct {
      kind_type           kind;
      logic [3:0]         field_id;
      logic [7:0]         char_out;
      logic signed [32:0] value;
      logic [15:0]        tag;
      logic               last;
   } parse_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [7:0]         req_byte_in = '0;
   logic               req_line_end = 1'b0;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [2:0]         rsp_kind;
   logic [3:0]         rsp_field_id;
   logic [7:0]         rsp_char_out;
   logic signed [32:0] rsp_value;
   logic [15:0]        rsp_tag;
   logic               rsp_last;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;

   // parser state mirror
   logic [3:0]  cur_field = '0;
   logic [31:0] num_acc = '0;
   logic        neg_seen = 1'b0;
   logic [2:0]  opt_pos = '0;
   logic [7:0]  tag_hi = '0;

   parse_result_type parsed_due[$];
   logic [7:0]       line_bytes[$];

   int  send_idle = 0;
   int  recv_idle = 0;
   int  bytes_sent = 0;
   int  lines_sent = 0;
   int  errors = 0;
   int  kind_seen[5] = '{default: 0};
   logic hold_on = 1'b0;
   event hold_start;

   sam_record_field_parser_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_byte_in  (req_byte_in),
      .req_line_end (req_line_end),
      .req_push     (req_push),
      .req_full     (req_full),
      .rsp_kind     (rsp_kind),
      .rsp_field_id (rsp_field_id),
      .rsp_char_out (rsp_char_out),
      .rsp_value    (rsp_value),
      .rsp_tag      (rsp_tag),
      .rsp_last     (rsp_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------- prediction ----------------

   function automatic bit numeric_field(input logic [3:0] f);
      return (f == FIELD_FLAG) || (f == FIELD_POS) || (f == FIELD_MAPQ) ||
             (f == FIELD_PNEXT) || (f == FIELD_TLEN);
   endfunction

   function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [7:0] b);
      logic [35:0] v;
      v = {4'b0, a} * 36'd10 + {28'b0, b - CH_ZERO};
      return (v > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic signed [32:0] field_number(input logic [3:0] f);
      logic [31:0] mag;
      if (f == FIELD_FLAG)
         return {1'b0, num_acc & FLAG_MASK};
      if (f == FIELD_TLEN && neg_seen) begin
         mag = (num_acc > TLEN_NEG_LIMIT) ? TLEN_NEG_LIMIT : num_acc;
         return 33'd0 - {1'b0, mag};
      end
      return {1'b0, num_acc};
   endfunction

   function automatic parse_result_type mk_result(input kind_type k, input logic [3:0] fid,
                                                  input logic [7:0] ch,
                                                  input logic signed [32:0] v,
                                                  input logic [15:0] t, input logic l);
      parse_result_type r;
      r.kind = k;
      r.field_id = fid;
      r.char_out = ch;
      r.value = v;
      r.tag = t;
      r.last = l;
      return r;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                     output parse_result_type r);
      logic [3:0] f;
      bit         got;
      bit         dig;
      f = cur_field;
      got = 1'b0;
      dig = (b >= CH_ZERO) && (b <= CH_NINE);
      r = mk_result(KIND_END, f, 8'd0, 33'sd0, 16'd0, 1'b1);
      if (b == CH_TAB) begin
         if (numeric_field(f)) begin
            r = mk_result(KIND_NUM, f, 8'd0, field_number(f), 16'd0, fin);
            got = 1'b1;
         end
         if (f < FIELD_OPT)
            cur_field = f + 4'd1;
         num_acc = '0;
         neg_seen = 1'b0;
         opt_pos = '0;
      end else if (numeric_field(f)) begin
         if (dig)
            num_acc = add_digit(num_acc, b);
         else if (b == CH_MINUS)
            neg_seen = 1'b1;
         if (fin) begin
            r = mk_result(KIND_NUM, f, 8'd0, field_number(f), 16'd0, 1'b1);
            got = 1'b1;
         end
      end else if (f == FIELD_CIGAR) begin
         if (dig) begin
            num_acc = add_digit(num_acc, b);
         end else begin
            r = mk_result(KIND_CIGAR, f, b, {1'b0, num_acc}, 16'd0, fin);
            got = 1'b1;
            num_acc = '0;
         end
      end else if (f >= FIELD_OPT) begin
         if (opt_pos == 3'd0) begin
            tag_hi = b;
         end else if (opt_pos == OPT_TAG_LAST) begin
            r = mk_result(KIND_TAG, FIELD_OPT, 8'd0, 33'sd0, {tag_hi, b}, fin);
            got = 1'b1;
         end else if (opt_pos >= OPT_VALUE_START) begin
            r = mk_result(KIND_TEXT, FIELD_OPT, b, 33'sd0, 16'd0, fin);
            got = 1'b1;
         end
         if (opt_pos < OPT_VALUE_START)
            opt_pos = opt_pos + 3'd1;
      end else begin
         r = mk_result(KIND_TEXT, f, b, 33'sd0, 16'd0, fin);
         got = 1'b1;
      end
      if (fin) begin
         if (!got) begin
            r = mk_result(KIND_END, f, 8'd0, 33'sd0, 16'd0, 1'b1);
            got = 1'b1;
         end
         cur_field = '0;
         num_acc = '0;
         neg_seen = 1'b0;
         opt_pos = '0;
         tag_hi = '0;
      end
      return got;
   endfunction

   // ---------------- checking ----------------

   always @(posedge clock) begin
      parse_result_type r;
      parse_result_type e;
      if (!reset) begin
         if (req_push && !req_full) begin
            if (parse_byte(req_byte_in, req_line_end, r))
               parsed_due.push_back(r);
         end
         if (rsp_pop && !rsp_empty) begin
            if (parsed_due.size() == 0) begin
               $error("result with none pending: kind %0d field_id %0d", rsp_kind,
                      rsp_field_id);
               errors++;
            end else begin
               e = parsed_due.pop_front();
               kind_seen[e.kind]++;
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d, got %0d", e.kind, rsp_kind);
                  errors++;
               end
               if (rsp_field_id !== e.field_id) begin
                  $error("field_id: expected %0d, got %0d", e.field_id, rsp_field_id);
                  errors++;
               end
               if (rsp_char_out !== e.char_out) begin
                  $error("char_out: expected %0d, got %0d", e.char_out, rsp_char_out);
                  errors++;
               end
               if (rsp_value !== e.value) begin
                  $error("value: expected %0d, got %0d", e.value, rsp_value);
                  errors++;
               end
               if (rsp_tag !== e.tag) begin
                  $error("tag: expected %h, got %h", e.tag, rsp_tag);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   // ---------------- result side ----------------

   initial begin
      forever begin
         @(posedge clock);
         rsp_pop <= !hold_on && ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      forever begin
         @(hold_start);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("sam_record_field_parser_top: mismatch");
      $finish;
   end

   // ---------------- line building ----------------

   function automatic void put_byte(input logic [7:0] b);
      line_bytes.push_back(b);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endfunction

   function automatic void put_text(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(255));
         if (b == CH_TAB)
            b = 8'h2A;
         put_byte(b);
      end
   endfunction

   function automatic void put_num();
      int n;
      case ($urandom_range(7))
         0: ;
         1: begin
            n = $urandom_range(10, 12);
            for (int i = 0; i < n; i++)
               put_byte(8'(CH_ZERO + $urandom_range(9)));
         end
         2: put_str($sformatf("%0d", $urandom()));
         default: put_str($sformatf("%0d", $urandom_range(99999)));
      endcase
   endfunction

   function automatic void put_cigar();
      string ops;
      int    n;
      ops = "MIDNSHP=X";
      if ($urandom_range(5) == 0) begin
         put_str("*");
      end else begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) != 0)
               put_str($sformatf("%0d", $urandom_range(1, 999)));
            put_byte(ops[$urandom_range(8)]);
         end
         if ($urandom_range(5) == 0)
            put_str($sformatf("%0d", $urandom_range(99)));
      end
   endfunction

   function automatic void put_noise();
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: put_byte(CH_TAB);
            1: put_byte(8'(CH_ZERO + $urandom_range(9)));
            2: put_byte(CH_MINUS);
            default: put_byte(8'($urandom_range(255)));
         endcase
      end
   endfunction

   function automatic void build_record();
      string bases;
      int    n;
      bases = "ACGTN";
      put_text($urandom_range(1, 4));
      put_byte(CH_TAB);
      put_num();
      put_byte(CH_TAB);
      put_text($urandom_range(1, 3));
      put_byte(CH_TAB);
      put_num();
      put_byte(CH_TAB);
      put_num();
      put_byte(CH_TAB);
      put_cigar();
      put_byte(CH_TAB);
      if ($urandom_range(1))
         put_str("=");
      else
         put_text($urandom_range(1, 3));
      put_byte(CH_TAB);
      put_num();
      put_byte(CH_TAB);
      if ($urandom_range(1))
         put_byte(CH_MINUS);
      put_num();
      put_byte(CH_TAB);
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         put_byte(bases[$urandom_range(4)]);
      put_byte(CH_TAB);
      put_text(n);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         put_byte(CH_TAB);
         put_text(2);
         put_str($urandom_range(1) ? ":i:" : ":Z:");
         put_text($urandom_range(0, 3));
      end
   endfunction

   // ---------------- input side ----------------

   task automatic send_item(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_byte_in <= b;
      req_line_end <= fin;
      do
         @(posedge clock);
      while (req_full);
      bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_item(line_bytes[i], i == line_bytes.size() - 1);
      line_bytes.delete();
      lines_sent++;
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      send_idle = 0;
      recv_idle = 0;
      put_str("x");
      send_line();
      put_byte(CH_TAB);
      send_line();
      put_str("\t99999999999");
      send_line();
      // empty numerics, cigar letter without length, dropped digits,
      // saturated negative tlen, tag then value
      put_str("\t\t\t\t\tM12\t\t\t-5000000000\t\t\tXY:Z:v");
      send_line();
   endtask

   task automatic test_random(input int s_idle, input int r_idle, input int n);
      int start;
      send_idle = s_idle;
      recv_idle = r_idle;
      start = bytes_sent;
      while (bytes_sent - start < n) begin
         case ($urandom_range(5))
            0: put_noise();
            1: begin
               build_record();
               line_bytes = line_bytes[0 : $urandom_range(line_bytes.size() - 1)];
            end
            default: build_record();
         endcase
         send_line();
      end
   endtask

   task automatic test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      -> hold_start;
      put_text(40);
      send_line();
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (parsed_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(29, 59, 90);
      test_backpressure();
      test_random(59, 29, 90);
      test_random(0, 0, 70);
      drain();
      $display("sent %0d bytes in %0d lines, results: %0d text, %0d numeric, %0d cigar,",
               bytes_sent, lines_sent, kind_seen[KIND_TEXT], kind_seen[KIND_NUM],
               kind_seen[KIND_CIGAR]);
      $display("%0d tag, %0d line-end only; one long result stall with input full",
               kind_seen[KIND_TAG], kind_seen[KIND_END]);
      if (errors == 0)
         $display("sam_record_field_parser_top: match");
      else
         $display("sam_record_field_parser_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
